// ----- hdl/three_rotor_enigma_cipher_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the three-rotor cipher block
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef THREE_ROTOR_ENIGMA_CIPHER_MACROS_SVH
`define THREE_ROTOR_ENIGMA_CIPHER_MACROS_SVH

// Check a property on every rising edge of clk outside reset
`define TREC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check that a signal holds in the cycle after a condition
`define TREC_ASSERT_HOLD(lbl, cond, sig, msg) \
	`TREC_ASSERT(lbl, cond |=> $stable(sig), msg)

`endif

// ----- hdl/trec_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trec_pkg
// Shared types, codes and constants of the three-rotor cipher block.
// ----------------------------------------------------------------------------
package trec_pkg;

	localparam int FIELD_W           = 5;
	localparam int DEF_ALPHABET_SIZE = 26;
	localparam int NUM_ROTORS        = 3;
	localparam int CFG_COUNT         = 3;
	localparam int CFG_IDX_W         = $clog2(CFG_COUNT);
	// one wiring bank per lookup, one pipeline stage per bank
	localparam int PIPE_STAGES       = 2 * NUM_ROTORS;
	localparam int INFL_W            = $clog2(PIPE_STAGES + 1);
	// output queue holds every word in flight plus two
	localparam int OUT_DEPTH         = 8;
	localparam int LVL_W             = $clog2(OUT_DEPTH + 1);

	typedef logic [FIELD_W-1:0] field_t;

	typedef enum logic [1:0] {
		REQ_LOAD    = 2'd0,
		REQ_ENCRYPT = 2'd1,
		REQ_RESTART = 2'd2
	} req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FAST_START    = 2'd0,
		CFG_MEDIUM_OFFSET = 2'd1,
		CFG_SLOW_OFFSET   = 2'd2
	} cfg_idx_t;

	// residue of every field value modulo the alphabet
	typedef logic [2**FIELD_W-1:0][FIELD_W-1:0] mod_tbl_t;

	// configuration write as seen by the datapath
	typedef struct packed {
		logic                 wen;
		logic [CFG_IDX_W-1:0] index;
		field_t               data;
	} cfg_wr_t;

	// datapath status toward the output queue and the input stall
	typedef struct packed {
		logic              push;
		field_t            letter;
		logic [INFL_W-1:0] inflight;
	} pipe_stat_t;

	// build the residue table by counting, no division
	function automatic mod_tbl_t mod_table(int n);
		mod_tbl_t t;
		int r;
		r = 0;
		for (int i = 0; i < 2**FIELD_W; i++) begin
			t[i] = FIELD_W'(r);
			r = (r + 1 == n) ? 0 : r + 1;
		end
		return t;
	endfunction

endpackage

// ----- hdl/trec_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trec_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module trec_ram #(
	parameter int WIDTH = 5,
	parameter int DEPTH = 26
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write one entry, register one read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hdl/trec_pipe.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trec_pipe
// Six-stage lookup pipeline over the rotor wiring banks, with the rotor
// position registers and the fast rotor stepping.
// ----------------------------------------------------------------------------
module trec_pipe import trec_pkg::*; #(
	parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       take,
	input  logic [1:0] req_type,
	input  logic [1:0] rotor_select,
	input  field_t     wiring_index,
	input  field_t     wiring_value,
	input  field_t     plain_letter,
	input  cfg_wr_t    cfg,
	output pipe_stat_t stat
);

	localparam int             LW      = $clog2(ALPHABET_SIZE);
	localparam mod_tbl_t       MOD_TBL = mod_table(ALPHABET_SIZE);
	localparam logic [LW:0]    N_EXT   = (LW+1)'(ALPHABET_SIZE);
	localparam logic [LW-1:0]  N_TOP   = LW'(ALPHABET_SIZE - 1);

	typedef struct packed {
		logic          enc;
		logic          ld;
		logic [1:0]    sel;
		logic [LW-1:0] idx;
		logic [LW-1:0] val;
		logic [LW-1:0] pf;
	} stage_t;

	// (a + b) mod N for a, b below N
	function automatic logic [LW-1:0] add_mod(input logic [LW-1:0] a, input logic [LW-1:0] b);
		logic [LW:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= N_EXT) begin
			s = s - N_EXT;
		end
		return s[LW-1:0];
	endfunction

	// (a - b) mod N for a, b below N
	function automatic logic [LW-1:0] sub_mod(input logic [LW-1:0] a, input logic [LW-1:0] b);
		logic [LW:0] d;
		if (a >= b) begin
			d = {1'b0, a} - {1'b0, b};
		end else begin
			d = {1'b0, a} + N_EXT - {1'b0, b};
		end
		return d[LW-1:0];
	endfunction

	logic [LW-1:0] fast_start_q;
	logic [LW-1:0] medium_q;
	logic [LW-1:0] slow_q;
	logic [LW-1:0] fp_q;
	logic [LW-1:0] pf_next;
	logic [LW-1:0] letter_in;
	logic [LW-1:0] l1, l2, l3, l4, l5, refl;

	stage_t st0;
	stage_t st_s1, st_s2, st_s3, st_s4, st_s5, st_s6;
	stage_t stg [PIPE_STAGES];

	logic          bank_we    [PIPE_STAGES];
	logic [LW-1:0] bank_waddr [PIPE_STAGES];
	logic [LW-1:0] bank_wdata [PIPE_STAGES];
	logic [LW-1:0] raddr      [PIPE_STAGES];
	logic [LW-1:0] rdata      [PIPE_STAGES];

	// hold rotor positions, reduced on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_start_q <= '0;
			medium_q     <= '0;
			slow_q       <= '0;
		end else if (cfg.wen) begin
			case (cfg.index)
				CFG_FAST_START:    fast_start_q <= MOD_TBL[cfg.data][LW-1:0];
				CFG_MEDIUM_OFFSET: medium_q     <= MOD_TBL[cfg.data][LW-1:0];
				CFG_SLOW_OFFSET:   slow_q       <= MOD_TBL[cfg.data][LW-1:0];
				default: ;
			endcase
		end
	end

	// advance the fast rotor on encrypt, reload it on restart
	assign pf_next = (fp_q == N_TOP) ? '0 : fp_q + LW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fp_q <= '0;
		end else if (take && req_type == REQ_ENCRYPT) begin
			fp_q <= pf_next;
		end else if (take && req_type == REQ_RESTART) begin
			fp_q <= fast_start_q;
		end
	end

	// decode the accepted word into stage zero
	always_comb begin
		st0.enc = take && req_type == REQ_ENCRYPT;
		st0.ld  = take && req_type == REQ_LOAD
			&& rotor_select < 2'(NUM_ROTORS)
			&& {1'b0, wiring_index} < (FIELD_W+1)'(ALPHABET_SIZE)
			&& {1'b0, wiring_value} < (FIELD_W+1)'(ALPHABET_SIZE);
		st0.sel = rotor_select;
		st0.idx = wiring_index[LW-1:0];
		st0.val = wiring_value[LW-1:0];
		st0.pf  = pf_next;
	end

	// advance every stage each cycle; the pipeline never stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_s1 <= '0;
			st_s2 <= '0;
			st_s3 <= '0;
			st_s4 <= '0;
			st_s5 <= '0;
			st_s6 <= '0;
		end else begin
			st_s1 <= st0;
			st_s2 <= st_s1;
			st_s3 <= st_s2;
			st_s4 <= st_s3;
			st_s5 <= st_s4;
			st_s6 <= st_s5;
		end
	end

	always_comb begin
		stg[0] = st0;
		stg[1] = st_s1;
		stg[2] = st_s2;
		stg[3] = st_s3;
		stg[4] = st_s4;
		stg[5] = st_s5;
	end

	// chain the lookups: each stage reads the bank of its own pass
	always_comb begin
		letter_in = MOD_TBL[plain_letter][LW-1:0];
		raddr[0]  = add_mod(letter_in, pf_next);
		l1        = sub_mod(rdata[0], st_s1.pf);
		raddr[1]  = add_mod(l1, medium_q);
		l2        = sub_mod(rdata[1], medium_q);
		raddr[2]  = add_mod(l2, slow_q);
		l3        = sub_mod(rdata[2], slow_q);
		refl      = N_TOP - l3;
		raddr[3]  = add_mod(refl, slow_q);
		l4        = sub_mod(rdata[3], slow_q);
		raddr[4]  = add_mod(l4, medium_q);
		l5        = sub_mod(rdata[4], medium_q);
		raddr[5]  = add_mod(l5, st_s5.pf);
	end

	// Banks 0..2 hold forward wiring of fast, medium, slow; banks 3..5 the
	// inverse wiring of slow, medium, fast. A load writes each bank in the
	// same stage that reads it, so reads and writes of a bank stay in word
	// order and no forwarding is needed.
	for (genvar b = 0; b < PIPE_STAGES; b++) begin : g_bank
		localparam bit INV = (b >= NUM_ROTORS);
		localparam int ROT = INV ? (PIPE_STAGES - 1 - b) : b;

		assign bank_we[b]    = stg[b].ld && stg[b].sel == 2'(ROT);
		assign bank_waddr[b] = INV ? stg[b].val : stg[b].idx;
		assign bank_wdata[b] = INV ? stg[b].idx : stg[b].val;

		trec_ram #(
			.WIDTH (LW),
			.DEPTH (ALPHABET_SIZE)
		) u_bank (
			.clk   (clk),
			.we    (bank_we[b]),
			.waddr (bank_waddr[b]),
			.wdata (bank_wdata[b]),
			.raddr (raddr[b]),
			.rdata (rdata[b])
		);
	end

	// finish the last pass and report words in flight
	always_comb begin
		stat.push     = st_s6.enc;
		stat.letter   = FIELD_W'(sub_mod(rdata[5], st_s6.pf));
		stat.inflight = INFL_W'($countones({st_s1.enc, st_s2.enc, st_s3.enc,
			st_s4.enc, st_s5.enc, st_s6.enc}));
	end

endmodule

// ----- hdl/trec_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trec_fifo
// Output queue that absorbs cipher words still in flight while the
// receiving side stalls.
// ----------------------------------------------------------------------------
module trec_fifo import trec_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  pipe_stat_t       stat,
	input  logic             stall,
	output logic             valid,
	output field_t           data,
	output logic [LVL_W-1:0] level
);

	localparam int PW = $clog2(OUT_DEPTH);

	field_t           mem_q [OUT_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [LVL_W-1:0] level_q;
	logic             pop;

	assign valid = level_q != '0;
	assign data  = mem_q[rd_ptr_q];
	assign level = level_q;
	assign pop   = valid && !stall;

	// store pushed words
	always_ff @(posedge clk) begin
		if (stat.push) begin
			mem_q[wr_ptr_q] <= stat.letter;
		end
	end

	// advance pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (stat.push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(OUT_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(OUT_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({stat.push, pop})
				2'b10:   level_q <= level_q + LVL_W'(1);
				2'b01:   level_q <= level_q - LVL_W'(1);
				default: level_q <= level_q;
			endcase
		end
	end

endmodule

// ----- hdl/three_rotor_enigma_cipher.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_rotor_enigma_cipher
// Three-rotor substitution cipher: wiring loads, encryption and fast rotor
// restart over a six-bank lookup pipeline with an output queue.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake            Payload
// cfg      in   cfg_wen              cfg_index, cfg_data
// in       in   in_valid / in_stall  req_type, rotor_select, wiring_index,
//                                    wiring_value, plain_letter
// out      out  out_valid / out_stall cipher_letter
//
// One word is accepted per cycle while in_stall is low; an encrypt word
// shows at the output after each of the six wiring bank reads and the
// output queue write.
// in_stall is high in the first cycle after reset and whenever the output
// queue level plus the encrypt words in flight reach the queue depth of 8.
// Wiring banks are not cleared by reset; an entry reads as written.
// ----------------------------------------------------------------------------
module three_rotor_enigma_cipher import trec_pkg::*; #(
	parameter int ALPHABET_SIZE = DEF_ALPHABET_SIZE
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  field_t               cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           req_type,
	input  logic [1:0]           rotor_select,
	input  field_t               wiring_index,
	input  field_t               wiring_value,
	input  field_t               plain_letter,
	output logic                 out_valid,
	input  logic                 out_stall,
	output field_t               cipher_letter
);

	localparam int SUM_W = LVL_W + 1;

	logic             run_q;
	logic             take;
	logic [LVL_W-1:0] level;
	logic [SUM_W-1:0] occupied;
	cfg_wr_t          cfg;
	pipe_stat_t       stat;

	// come out of reset through the run_q register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
		end else begin
			run_q <= 1'b1;
		end
	end

	// stall when the queue could not absorb one more word
	assign occupied = SUM_W'(level) + SUM_W'(stat.inflight);
	assign in_stall = !run_q || occupied >= SUM_W'(OUT_DEPTH);
	assign take     = in_valid && !in_stall;

	assign cfg.wen   = cfg_wen;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	trec_pipe #(
		.ALPHABET_SIZE (ALPHABET_SIZE)
	) u_pipe (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.req_type     (req_type),
		.rotor_select (rotor_select),
		.wiring_index (wiring_index),
		.wiring_value (wiring_value),
		.plain_letter (plain_letter),
		.cfg          (cfg),
		.stat         (stat)
	);

	trec_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.stall  (out_stall),
		.valid  (out_valid),
		.data   (cipher_letter),
		.level  (level)
	);

endmodule

// ----- hdl/trec_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trec_checker
// Port-level checks of the cipher block, bound to the top level.
// ----------------------------------------------------------------------------
`include "three_rotor_enigma_cipher_macros.svh"

module trec_checker import trec_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic [1:0] req_type,
	input logic       out_valid,
	input logic       out_stall,
	input field_t     cipher_letter
);

	// hold a stalled output word
	`TREC_ASSERT(a_out_valid_hold, out_valid && out_stall |=> out_valid, "out word dropped while stalled")
	`TREC_ASSERT_HOLD(a_out_data_hold, out_valid && out_stall, cipher_letter, "out word changed while stalled")

	// a word leaving an empty queue comes from an accepted encrypt word
	`TREC_ASSERT(a_word_latency, $rose(out_valid) |-> $past(in_valid && !in_stall && req_type == REQ_ENCRYPT, 7), "out word without matching encrypt")

	// once running, input stalls only behind pending output words
	`TREC_ASSERT(a_stall_cause, $past(arst_n) && in_stall |-> out_valid, "input stalled with empty output")

endmodule

bind three_rotor_enigma_cipher trec_checker u_trec_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_stall      (in_stall),
	.req_type      (req_type),
	.out_valid     (out_valid),
	.out_stall     (out_stall),
	.cipher_letter (cipher_letter)
);
